// ===== hw/rtl/sshf_pkg.sv =====
// shared types, constants and character helpers for the sensor scan hex frame fifo
package sshf_pkg;

  localparam int DefFifoDepth = 64;
  localparam int FrameLen     = 12;
  localparam int FillW        = 6;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;

  // three samples of one scan, rendered to text on the way out
  typedef struct packed {
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    frame_rec_t rec;
  } queue_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       has_room;
    logic [7:0] head_byte;
  } queue_sts_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'b0, nib};
    end else begin
      ch = ChLowA + {4'b0, nib} - 8'd10;
    end
    return ch;
  endfunction

  // character at position pos of the frame "hh, hh, hh\r\n"
  function automatic logic [7:0] frame_char(input frame_rec_t rec, input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = hex_digit(rec.s0[7:4]);
      4'd1:    ch = hex_digit(rec.s0[3:0]);
      4'd2:    ch = ChComma;
      4'd3:    ch = ChSpace;
      4'd4:    ch = hex_digit(rec.s1[7:4]);
      4'd5:    ch = hex_digit(rec.s1[3:0]);
      4'd6:    ch = ChComma;
      4'd7:    ch = ChSpace;
      4'd8:    ch = hex_digit(rec.s2[7:4]);
      4'd9:    ch = hex_digit(rec.s2[3:0]);
      4'd10:   ch = ChCr;
      4'd11:   ch = ChLf;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/sensor_scan_hex_frame_fifo.sv =====
// top level: channel sequencing, frame build, byte fifo and result register
//
// usage
//   input channel: in_valid_i / in_stall_o carry one item per accepted edge,
//   operation_i selects a converter sample (0) or a transmitter-ready slot (1)
//   samples come for channels 0, 1, 2 in turn; channels 0 and 1 are held and
//   the channel 2 sample turns all three into "hh, hh, hh\r\n" (12 bytes)
//   a frame goes into the byte fifo whole when 12 entries are free, otherwise
//   it is dropped and frame_dropped_o is raised for that item
//   a ready item pops one byte (tx_valid_o, tx_byte_o) or reports tx_idle_o
//   output channel: one result item per input item, out_valid_o / out_stall_i
// timing
//   result shows in the output register in the cycle after the item is taken;
//   one item per cycle sustained while out_stall_i is low, set by the single result register stage
//   frames are kept as sample records and rendered one character per pop, so
//   a push is one record write and a pop one record read plus a mux
// reset: pointers, channel and held samples clear, output register empties
// stall: while a result waits under out_stall_i, in_stall_o is high and no
//   new item is taken; a result that is taken frees the slot in the same edge
module sensor_scan_hex_frame_fifo
  import sshf_pkg::*;
#(
  parameter int FIFO_DEPTH = DefFifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] sample_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_idle_o,
  output logic       frame_accepted_o,
  output logic       frame_dropped_o,
  output logic [5:0] fill_level_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READY  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CH_0 = 2'd0,
    CH_1 = 2'd1,
    CH_2 = 2'd2
  } chan_e;

  chan_e           chan_q, chan_d;
  logic [7:0]      held0_q, held0_d, held1_q, held1_d;
  logic            accept;
  queue_cmd_t      qcmd;
  queue_sts_t      qsts;
  logic [PtrW-1:0] fill_nxt;
  logic [PtrW+5:0] fill_ext;

  // result register
  logic       out_valid_q;
  logic       tx_valid_q, tx_valid_d;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic       tx_idle_q, tx_idle_d;
  logic       acc_q, acc_d;
  logic       drop_q, drop_d;
  logic [5:0] fill_q;

  // the slot frees when empty or when its item leaves this edge
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    chan_d     = chan_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    qcmd.push  = 1'b0;
    qcmd.pop   = 1'b0;
    qcmd.rec   = '{s0: held0_q, s1: held1_q, s2: sample_i};
    tx_valid_d = 1'b0;
    tx_byte_d  = 8'h00;
    tx_idle_d  = 1'b0;
    acc_d      = 1'b0;
    drop_d     = 1'b0;
    case (op_e'(operation_i))
      OP_SAMPLE: begin
        case (chan_q)
          CH_0: begin
            held0_d = sample_i;
            chan_d  = CH_1;
          end
          CH_1: begin
            held1_d = sample_i;
            chan_d  = CH_2;
          end
          CH_2: begin
            chan_d = CH_0;
            if (qsts.has_room) begin
              qcmd.push = accept;
              acc_d     = 1'b1;
            end else begin
              drop_d = 1'b1;
            end
          end
          // channel three never occurs: sample ignored, channel kept
          default: chan_d = chan_q;
        endcase
      end
      OP_READY: begin
        if (qsts.empty) begin
          tx_idle_d = 1'b1;
        end else begin
          qcmd.pop   = accept;
          tx_valid_d = 1'b1;
          tx_byte_d  = qsts.head_byte;
        end
      end
      default: tx_idle_d = 1'b0;
    endcase
  end

  sshf_frame_queue #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (qcmd),
    .sts_o (qsts),
    .fill_o(fill_nxt)
  );

  // fill level reported modulo 64
  assign fill_ext = {6'b0, fill_nxt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= CH_0;
      held0_q     <= '0;
      held1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        chan_q  <= chan_d;
        held0_q <= held0_d;
        held1_q <= held1_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_valid_q <= tx_valid_d;
      tx_byte_q  <= tx_byte_d;
      tx_idle_q  <= tx_idle_d;
      acc_q      <= acc_d;
      drop_q     <= drop_d;
      fill_q     <= fill_ext[5:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_valid_o       = tx_valid_q;
  assign tx_byte_o        = tx_byte_q;
  assign tx_idle_o        = tx_idle_q;
  assign frame_accepted_o = acc_q;
  assign frame_dropped_o  = drop_q;
  assign fill_level_o     = fill_q;

endmodule

// ===== hw/rtl/sshf_frame_queue.sv =====
// byte fifo that stores whole frames as sample records and pops them one character at a time
module sshf_frame_queue
  import sshf_pkg::*;
#(
  parameter int FIFO_DEPTH = DefFifoDepth,
  localparam int PtrW = $clog2(FIFO_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  queue_cmd_t      cmd_i,
  output queue_sts_t      sts_o,
  output logic [PtrW-1:0] fill_o
);

  // enough record slots for the most bytes the ring can hold, head frame partly read
  localparam int SlotN = (FIFO_DEPTH - 1 + FrameLen - 1) / FrameLen;
  localparam int SlotW = $clog2(SlotN);
  localparam int RoomMax = FIFO_DEPTH - 1 - FrameLen;

  frame_rec_t       rec_q [SlotN];
  logic [SlotW-1:0] head_q, head_d, tail_q, tail_d;
  logic [3:0]       ofs_q, ofs_d;
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]    wp_sum;
  logic [PtrW:0]    diff_cur, diff_nxt;
  logic [PtrW-1:0]  fill_cur;

  function automatic logic [PtrW-1:0] fill_of(input logic [PtrW-1:0] wp,
                                              input logic [PtrW-1:0] rp);
    logic [PtrW:0] diff;
    diff = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      diff = diff + (PtrW+1)'(FIFO_DEPTH);
    end
    return diff[PtrW-1:0];
  endfunction

  assign diff_cur = {1'b0, fill_of(wp_q, rp_q)};
  assign fill_cur = diff_cur[PtrW-1:0];

  assign sts_o.empty     = (wp_q == rp_q);
  assign sts_o.has_room  = (fill_cur <= PtrW'(RoomMax));
  assign sts_o.head_byte = frame_char(rec_q[head_q], ofs_q);

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    head_d = head_q;
    tail_d = tail_q;
    ofs_d  = ofs_q;
    wp_sum = {1'b0, wp_q} + (PtrW+1)'(FrameLen);
    if (cmd_i.push) begin
      if (wp_sum >= (PtrW+1)'(FIFO_DEPTH)) begin
        wp_sum = wp_sum - (PtrW+1)'(FIFO_DEPTH);
      end
      wp_d   = wp_sum[PtrW-1:0];
      tail_d = (tail_q == SlotW'(SlotN - 1)) ? '0 : tail_q + 1'b1;
    end
    if (cmd_i.pop) begin
      rp_d = (rp_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (ofs_q == 4'(FrameLen - 1)) begin
        ofs_d  = '0;
        head_d = (head_q == SlotW'(SlotN - 1)) ? '0 : head_q + 1'b1;
      end else begin
        ofs_d = ofs_q + 4'd1;
      end
    end
  end

  assign diff_nxt = {1'b0, fill_of(wp_d, rp_d)};
  assign fill_o   = diff_nxt[PtrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      head_q <= '0;
      tail_q <= '0;
      ofs_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      head_q <= head_d;
      tail_q <= tail_d;
      ofs_q  <= ofs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      rec_q[tail_q] <= cmd_i.rec;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sensor scan hex frame fifo: directed and random items, scoreboard
module testbench;
  import sshf_pkg::*;

  // item codes on operation_i
  localparam bit OpSample = 1'b0;
  localparam bit OpReady  = 1'b1;

  // characters of the text frame
  localparam bit [7:0] AscZero  = "0";
  localparam bit [7:0] AscLowA  = "a";
  localparam bit [7:0] AscComma = ",";
  localparam bit [7:0] AscSpace = " ";
  localparam bit [7:0] AscCr    = 8'h0d;
  localparam bit [7:0] AscLf    = 8'h0a;

  localparam int unsigned ByteSlots  = 64;  // ring size, one slot always kept free
  localparam int unsigned FrameBytes = 12;
  localparam int unsigned ItemTarget = 750;

  // one result item, as seen on the output ports
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_idle;
    logic       accepted;
    logic       dropped;
    logic [5:0] fill;
  } tx_result_t;

  // scoreboard: shadow of the scan sequencer and byte ring, plus the results still owed
  class scan_scoreboard;
    bit [7:0]    ring_bytes [ByteSlots];
    bit [5:0]    wr_ptr;
    bit [5:0]    rd_ptr;
    bit [1:0]    chan;
    bit [7:0]    held0;
    bit [7:0]    held1;
    bit          xmit_active;
    tx_result_t  owed_q [$];
    int unsigned errors;

    function new();
      wr_ptr      = '0;
      rd_ptr      = '0;
      chan        = '0;
      held0       = '0;
      held1       = '0;
      xmit_active = 1'b0;
      errors      = 0;
    endfunction

    function bit [7:0] hex_char(bit [3:0] nib);
      if (nib < 4'd10) return AscZero + 8'(nib);
      return AscLowA + 8'(nib) - 8'd10;
    endfunction

    // work out the result of one accepted input item
    function void note_item(bit op, bit [7:0] smp);
      tx_result_t res;
      bit [7:0]   frame [FrameBytes];
      bit [5:0]   fill;
      res  = '0;
      fill = wr_ptr - rd_ptr;
      if (op == OpSample) begin
        case (chan)
          2'd0: begin
            held0 = smp;
            chan  = 2'd1;
          end
          2'd1: begin
            held1 = smp;
            chan  = 2'd2;
          end
          2'd2: begin
            frame[0]  = hex_char(held0[7:4]);
            frame[1]  = hex_char(held0[3:0]);
            frame[2]  = AscComma;
            frame[3]  = AscSpace;
            frame[4]  = hex_char(held1[7:4]);
            frame[5]  = hex_char(held1[3:0]);
            frame[6]  = AscComma;
            frame[7]  = AscSpace;
            frame[8]  = hex_char(smp[7:4]);
            frame[9]  = hex_char(smp[3:0]);
            frame[10] = AscCr;
            frame[11] = AscLf;
            chan = 2'd0;
            if (ByteSlots - 1 - fill >= FrameBytes) begin
              foreach (frame[i]) begin
                ring_bytes[wr_ptr] = frame[i];
                wr_ptr++;
              end
              xmit_active  = 1'b1;
              res.accepted = 1'b1;
            end else begin
              res.dropped = 1'b1;
            end
          end
          default: ;  // channel three: sample ignored
        endcase
      end else begin
        if (wr_ptr == rd_ptr) begin
          xmit_active = 1'b0;
          res.tx_idle = 1'b1;
        end else begin
          res.tx_byte  = ring_bytes[rd_ptr];
          res.tx_valid = 1'b1;
          rd_ptr++;
        end
      end
      res.fill = wr_ptr - rd_ptr;
      owed_q.push_back(res);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tx_result_t got);
      tx_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed, got %p", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      cmp_field("tx_byte", want.tx_byte, got.tx_byte);
      cmp_field("tx_idle", 8'(want.tx_idle), 8'(got.tx_idle));
      cmp_field("frame_accepted", 8'(want.accepted), 8'(got.accepted));
      cmp_field("frame_dropped", 8'(want.dropped), 8'(got.dropped));
      cmp_field("fill_level", 8'(want.fill), 8'(got.fill));
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       operation_i;
  logic [7:0] sample_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       tx_idle_o;
  logic       frame_accepted_o;
  logic       frame_dropped_o;
  logic [5:0] fill_level_o;

  scan_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    calm_left;   // items still to send back to back

  sensor_scan_hex_frame_fifo u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .tx_idle_o       (tx_idle_o),
    .frame_accepted_o(frame_accepted_o),
    .frame_dropped_o (frame_dropped_o),
    .fill_level_o    (fill_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both handshakes are sampled here, input first, so a prediction is always in
  // place before any result it could match
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(operation_i, sample_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({tx_valid_o, tx_byte_o, tx_idle_o, frame_accepted_o,
                         frame_dropped_o, fill_level_o});
      end
    end
  end

  // sender gap: mostly none or short, now and then long, with runs of no gaps
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(10, 40);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sample values lean on the hex digit edges now and then
  function automatic bit [7:0] pick_sample();
    bit [7:0] corner [8] = '{8'h00, 8'hff, 8'h09, 8'h0a, 8'h90, 8'ha0, 8'h99, 8'haa};
    if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // hold one item until it is taken, then maybe leave a gap
  task automatic send_item(input bit op, input bit [7:0] smp);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    sample_i    <= smp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i  <= 1'b0;
      operation_i <= 1'($urandom);
      sample_i    <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input bit [7:0] s0, input bit [7:0] s1, input bit [7:0] s2);
    send_item(OpSample, s0);
    send_item(OpSample, s1);
    send_item(OpSample, s2);
  endtask

  // receiver stall: runs of random length, some quiet stretches, a few long stalls
  initial begin
    int unsigned run_left;
    int unsigned r;
    out_stall_i <= 1'b0;
    run_left = 0;
    forever begin
      @(posedge clk_i);
      if (run_left != 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_stall_i <= 1'b0;
          run_left = $urandom_range(10, 60);
        end else if (r < 60) begin
          out_stall_i <= 1'b0;
          run_left = $urandom_range(0, 3);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(0, 3);
        end else begin
          out_stall_i <= 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned pop_pct;
    sb          = new();
    items_sent  = 0;
    calm_left   = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OpSample;
    sample_i    <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ready on an empty fifo goes idle
    send_item(OpReady, 8'h5a);
    // five frames covering digit extremes, fifo up to 60 bytes
    send_frame(8'h00, 8'h00, 8'h00);
    send_frame(8'hff, 8'hff, 8'hff);
    send_frame(8'h09, 8'h0a, 8'h90);
    send_frame(8'ha0, 8'h9f, 8'hf9);
    send_frame(8'h5c, 8'h3e, 8'hd1);
    // pop down to 51 bytes so exactly twelve entries are free, then fill to 63
    repeat (9) send_item(OpReady, 8'hff);
    send_frame(8'h12, 8'hab, 8'hef);

    // random scenarios: mixed streams, floods that overrun the ring, drains past empty
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n       = $urandom_range(10, 60);
        pop_pct = $urandom_range(25, 75);
        repeat (n) begin
          if ($urandom_range(0, 99) < pop_pct) send_item(OpReady, 8'($urandom));
          else send_item(OpSample, pick_sample());
        end
      end else if (pick < 75) begin
        n = $urandom_range(4, 7);
        repeat (n) send_frame(pick_sample(), pick_sample(), pick_sample());
        n = $urandom_range(0, 20);
        repeat (n) send_item(OpReady, 8'($urandom));
      end else begin
        n = $urandom_range(20, 75);
        repeat (n) send_item(OpReady, 8'($urandom));
      end
    end

    // drop valid in the edge that took the last item so it is not taken twice
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
